>>> hdl/mwpid_pkg.sv
// Shared types, constants and helpers for the multi-wheel PID speed controller.
// Used by the register bank, controller, datapath and top level.
package mwpid_pkg;

	localparam int WHEEL_COUNT = 4;
	localparam int WHEEL_W     = 2;
	localparam int SPEED_W     = 19;
	localparam int ERR_W       = 20;
	localparam int DIFF_W      = 21;
	localparam int INTEG_W     = 32;
	localparam int GAIN_W      = 16;
	localparam int GAIN_REG_W  = 64;
	localparam int TF_W        = 16;
	localparam int DRIVE_W     = 13;
	localparam int CFG_IDX_W   = 3;

	// shared multiplier: signed A x signed B (B is a zero-extended Q8.8 value)
	localparam int MUL_A_W     = 38;
	localparam int MUL_B_W     = GAIN_W + 1;
	localparam int PROD_W      = MUL_A_W + MUL_B_W;
	localparam int ACC_W       = 49;

	localparam logic signed [ACC_W-1:0] CLAMP_HI = ACC_W'(50 * 65536);
	localparam logic signed [ACC_W-1:0] CLAMP_LO = -ACC_W'(50 * 65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP  = 3'd0,
		REG_KI  = 3'd1,
		REG_KD  = 3'd2,
		REG_TF  = 3'd3,
		REG_ITF = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_REG_W-1:0] kp;
		logic [GAIN_REG_W-1:0] ki;
		logic [GAIN_REG_W-1:0] kd;
		logic [TF_W-1:0]       tf;
		logic [TF_W-1:0]       itf;
	} cfg_regs_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MI,
		S_MIT,
		S_MD,
		S_MDT,
		S_MP,
		S_SUM,
		S_DONE
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_I,
		OP_MUL_IT,
		OP_MUL_D,
		OP_MUL_DT,
		OP_MUL_P,
		OP_SUM,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

	// pick one wheel's 16-bit gain out of a packed register
	function automatic logic [GAIN_W-1:0] gain_sel(input logic [GAIN_REG_W-1:0] r,
		input logic [WHEEL_W-1:0] w);
		logic [5:0] base;
		base = {w, 4'b0000};
		return r[base +: GAIN_W];
	endfunction

endpackage

>>> hdl/mwpid_regs.sv
// Configuration register bank: gains and time factors.
// Depends on mwpid_pkg.
module mwpid_regs
	import mwpid_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [GAIN_REG_W-1:0] cfg_data,
	output cfg_regs_t             regs
);

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.kp  <= '0;
			regs_q.ki  <= '0;
			regs_q.kd  <= '0;
			regs_q.tf  <= TF_W'(256);
			regs_q.itf <= TF_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KP:  regs_q.kp  <= cfg_data;
				REG_KI:  regs_q.ki  <= cfg_data;
				REG_KD:  regs_q.kd  <= cfg_data;
				REG_TF:  regs_q.tf  <= cfg_data[TF_W-1:0];
				REG_ITF: regs_q.itf <= cfg_data[TF_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

>>> hdl/mwpid_ctrl.sv
// Sequencer for one PID update: steps the shared multiplier through its five products.
// Depends on mwpid_pkg.
module mwpid_ctrl
	import mwpid_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	ctrl_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_MI;
			S_MI:    state_d = S_MIT;
			S_MIT:   state_d = S_MD;
			S_MD:    state_d = S_MDT;
			S_MDT:   state_d = S_MP;
			S_MP:    state_d = S_SUM;
			S_SUM:   state_d = S_DONE;
			S_DONE:  if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_MI:    cmd.op = OP_MUL_I;
			S_MIT:   cmd.op = OP_MUL_IT;
			S_MD:    cmd.op = OP_MUL_D;
			S_MDT:   cmd.op = OP_MUL_DT;
			S_MP:    cmd.op = OP_MUL_P;
			S_SUM:   cmd.op = OP_SUM;
			S_DONE:  if (sts.out_free) cmd.op = OP_OUT;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !sts.out_free) |=> state_q == S_DONE)
		else $error("controller left DONE with output slot busy");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == S_MI)
		else $error("accepted request did not start the multiply sequence");
`endif

endmodule

>>> hdl/mwpid_dp.sv
// Datapath: per-wheel integral and last error, shared multiplier, accumulator, clamp
// and output register. Depends on mwpid_pkg.
module mwpid_dp
	import mwpid_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_sts_t                    sts,
	input  cfg_regs_t                  regs,
	input  logic [WHEEL_W-1:0]         wheel_index,
	input  logic signed [SPEED_W-1:0]  measured_speed,
	input  logic signed [SPEED_W-1:0]  target_speed,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [WHEEL_W-1:0]         wheel_id,
	output logic signed [DRIVE_W-1:0]  drive_value,
	output logic                       was_clamped
);

	logic signed [INTEG_W-1:0] integral_q [WHEEL_COUNT];
	logic signed [ERR_W-1:0]   last_err_q [WHEEL_COUNT];

	logic [WHEEL_W-1:0]        wheel_q;
	logic                      wheel_ok_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [INTEG_W-1:0] old_int_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      out_valid_q;
	logic [WHEEL_W-1:0]        wheel_id_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic                      clamped_q;

	logic                          in_ok;
	logic signed [ERR_W-1:0]       err_d;
	logic signed [INTEG_W-1:0]     old_int_d;
	logic signed [ERR_W-1:0]       old_err_d;
	logic signed [MUL_A_W-1:0]     mul_a;
	logic signed [MUL_B_W-1:0]     mul_b;
	logic signed [PROD_W-1:0]      mul_p;
	logic signed [INTEG_W:0]       isum;
	logic signed [PROD_W-9:0]      prod_sh;
	logic signed [INTEG_W-1:0]     integ_sat;
	logic signed [ACC_W-1:0]       clamp_val;
	logic                          clamp_hit;

	assign in_ok     = 32'(wheel_index) < WHEEL_COUNT;
	assign err_d     = ERR_W'(measured_speed) - ERR_W'(target_speed);
	assign old_int_d = in_ok ? integral_q[wheel_index] : '0;
	assign old_err_d = in_ok ? last_err_q[wheel_index] : '0;

	// floor(prod / 256), used for the ki*err, integral and derivative terms
	assign prod_sh = prod_q[PROD_W-1:8];
	// old integral + floor(ki*err / 256); the shifted ki*err term fits 29 bits signed
	assign isum    = (INTEG_W+1)'(old_int_q) + (INTEG_W+1)'(prod_sh);

	always_comb begin
		if (prod_sh > (PROD_W-8)'(32'sh7FFF_FFFF)) begin
			integ_sat = 32'sh7FFF_FFFF;
		end else if (prod_sh < -(PROD_W-8)'(64'sh8000_0000)) begin
			integ_sat = 32'sh8000_0000;
		end else begin
			integ_sat = prod_sh[INTEG_W-1:0];
		end
	end

	// operand select for the one shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MUL_I: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = {1'b0, gain_sel(regs.ki, wheel_q)};
			end
			OP_MUL_IT: begin
				mul_a = MUL_A_W'(isum);
				mul_b = {1'b0, regs.itf};
			end
			OP_MUL_D: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = {1'b0, gain_sel(regs.kd, wheel_q)};
			end
			OP_MUL_DT: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = {1'b0, regs.tf};
			end
			OP_MUL_P: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = {1'b0, gain_sel(regs.kp, wheel_q)};
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		clamp_hit = 1'b0;
		clamp_val = acc_q;
		if (acc_q > CLAMP_HI) begin
			clamp_val = CLAMP_HI;
			clamp_hit = 1'b1;
		end else if (acc_q < CLAMP_LO) begin
			clamp_val = CLAMP_LO;
			clamp_hit = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				wheel_q    <= wheel_index;
				wheel_ok_q <= in_ok;
				err_q      <= err_d;
				diff_q     <= DIFF_W'(err_d) - DIFF_W'(old_err_d);
				old_int_q  <= old_int_d;
			end
			OP_MUL_I, OP_MUL_IT, OP_MUL_DT: prod_q <= mul_p;
			OP_MUL_D: begin
				integ_q <= integ_sat;
				prod_q  <= mul_p;
			end
			OP_MUL_P: begin
				acc_q  <= ACC_W'(prod_sh) + ACC_W'(signed'({integ_q, 8'h00}));
				prod_q <= mul_p;
			end
			OP_SUM:  acc_q <= acc_q + ACC_W'(prod_q);
			OP_OUT: begin
				wheel_id_q <= wheel_q;
				drive_q    <= clamp_val[DRIVE_W+9:10];
				clamped_q  <= clamp_hit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				integral_q[i] <= '0;
				last_err_q[i] <= '0;
			end
		end else if (cmd.op == OP_MUL_P && wheel_ok_q) begin
			integral_q[wheel_q] <= integ_q;
			last_err_q[wheel_q] <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign wheel_id     = wheel_id_q;
	assign drive_value  = drive_q;
	assign was_clamped  = clamped_q;

`ifndef ASSERT_OFF
	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |=> out_valid_q)
		else $error("result not presented after output load");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while stalled");
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (drive_q <= 13'sd3200 && drive_q >= -13'sd3200))
		else $error("drive value outside clamp range");
`endif

endmodule

>>> hdl/multi_wheel_pid_speed_controller.sv
// Top level of the multi-wheel PID speed controller.
// Depends on mwpid_pkg, mwpid_regs, mwpid_ctrl and mwpid_dp.
//
// Usage:
//  - Input channel (in_valid/in_stall): one request carries a wheel index and the
//    measured and target speed of that wheel in signed Q10.8.
//  - Output channel (out_valid/out_stall): one result per request with the wheel id,
//    the clamped drive value (signed, clamped raw drive / 1024) and a clamp flag.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): gains and time
//    factors; write only while no request is in flight. cfg_ready is always high.
// Timing: a request is taken in IDLE. One request is in flight at a time: the load
// step, five products in sequence on the single shared multiplier, the final sum
// and the output step, which loads the output register and raises out_valid.
// A new request is taken while the previous result still waits in the output
// register. If the receiver stalls, the finished request waits in its last step
// until the output register frees up, and in_stall stays high meanwhile.
// Reset clears the per-wheel integrals and last errors, zeroes the gains and sets
// both time factors to 1.0.
module multi_wheel_pid_speed_controller
	import mwpid_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [WHEEL_W-1:0]        wheel_index,
	input  logic signed [SPEED_W-1:0] measured_speed,
	input  logic signed [SPEED_W-1:0] target_speed,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [WHEEL_W-1:0]        wheel_id,
	output logic signed [DRIVE_W-1:0] drive_value,
	output logic                      was_clamped,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [GAIN_REG_W-1:0]     cfg_data
);

	cfg_regs_t regs;
	dp_cmd_t   cmd;
	dp_sts_t   sts;

	mwpid_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	mwpid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	mwpid_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.regs           (regs),
		.wheel_index    (wheel_index),
		.measured_speed (measured_speed),
		.target_speed   (target_speed),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.wheel_id       (wheel_id),
		.drive_value    (drive_value),
		.was_clamped    (was_clamped)
	);

endmodule

>>> sim/tb_multi_wheel_pid_speed_controller.sv
// Self-checking testbench for multi_wheel_pid_speed_controller: directed and random
// speed requests, checked result by result against a fixed-point PID predictor.
// Depends on mwpid_pkg and the controller RTL.
module tb_multi_wheel_pid_speed_controller;
	timeunit 1ns;
	timeprecision 1ps;

	import mwpid_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 6;
	localparam int HOLD_CYCLES     = 150;
	localparam int DRAIN_CYCLES    = 20;
	localparam int WATCHDOG_CYCLES = 1_000_000;
	localparam int RANDOM_PHASES   = 8;
	localparam int PHASE_REQUESTS  = 108;
	localparam int FRAC_W          = 8;
	localparam int DRIVE_SHIFT     = 10;
	localparam int GAIN_LANES      = GAIN_REG_W / GAIN_W;

	localparam longint INTEG_MAX = (longint'(1) <<< (INTEG_W - 1)) - 1;
	localparam longint INTEG_MIN = -(longint'(1) <<< (INTEG_W - 1));
	localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
	localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
	localparam logic [TF_W-1:0] Q8_ONE = 16'h0100;
	localparam logic [GAIN_REG_W-1:0] ALL_ONES = {GAIN_REG_W{1'b1}};

	typedef struct packed {
		logic [WHEEL_W-1:0]        wheel;
		logic signed [DRIVE_W-1:0] drive;
		logic                      clamped;
	} drive_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [WHEEL_W-1:0]        wheel_index = '0;
	logic signed [SPEED_W-1:0] measured_speed = '0;
	logic signed [SPEED_W-1:0] target_speed = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [WHEEL_W-1:0]        wheel_id;
	logic signed [DRIVE_W-1:0] drive_value;
	logic                      was_clamped;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [GAIN_REG_W-1:0]     cfg_data = '0;

	// predictor copy of registers and per-wheel state
	logic [GAIN_REG_W-1:0] kp_gains, ki_gains, kd_gains;
	logic [TF_W-1:0]       tf_q8, itf_q8;
	longint                integral_acc [WHEEL_COUNT];
	longint                prev_error [WHEEL_COUNT];

	drive_result_t pending_drives [$];
	int            mismatch_count = 0;
	bit            quiet = 1'b0;
	bit            hold_rx = 1'b0;
	int            stall_run = 0;
	bit            stall_level = 1'b0;

	multi_wheel_pid_speed_controller dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.wheel_index    (wheel_index),
		.measured_speed (measured_speed),
		.target_speed   (target_speed),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.wheel_id       (wheel_id),
		.drive_value    (drive_value),
		.was_clamped    (was_clamped),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic void model_reset();
		int k;
		kp_gains = '0;
		ki_gains = '0;
		kd_gains = '0;
		tf_q8 = Q8_ONE;
		itf_q8 = Q8_ONE;
		for (k = 0; k < WHEEL_COUNT; k++) begin
			integral_acc[k] = 0;
			prev_error[k] = 0;
		end
	endfunction

	// >>> on longint is a floor shift, matching the fixed-point spec
	function automatic drive_result_t predict_drive(input logic [WHEEL_W-1:0] w,
		input logic signed [SPEED_W-1:0] meas, input logic signed [SPEED_W-1:0] targ);
		longint err, kp, ki, kd, integ, deriv, raw;
		drive_result_t res;
		err = longint'(meas) - longint'(targ);
		kp = longint'(kp_gains[w*GAIN_W +: GAIN_W]);
		ki = longint'(ki_gains[w*GAIN_W +: GAIN_W]);
		kd = longint'(kd_gains[w*GAIN_W +: GAIN_W]);
		integ = ((integral_acc[w] + ((ki * err) >>> FRAC_W)) * longint'(itf_q8)) >>> FRAC_W;
		if (integ > INTEG_MAX) begin
			integ = INTEG_MAX;
		end else if (integ < INTEG_MIN) begin
			integ = INTEG_MIN;
		end
		deriv = (kd * (err - prev_error[w]) * longint'(tf_q8)) >>> FRAC_W;
		raw = kp * err + (integ <<< FRAC_W) + deriv;
		res.clamped = 1'b0;
		if (raw > longint'(CLAMP_HI)) begin
			raw = longint'(CLAMP_HI);
			res.clamped = 1'b1;
		end else if (raw < longint'(CLAMP_LO)) begin
			raw = longint'(CLAMP_LO);
			res.clamped = 1'b1;
		end
		res.wheel = w;
		res.drive = DRIVE_W'(raw >>> DRIVE_SHIFT);
		integral_acc[w] = integ;
		prev_error[w] = err;
		return res;
	endfunction

	// mostly short, now and then long
	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(3, 1);
		if (r < 95)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [GAIN_REG_W-1:0] random_gains();
		logic [GAIN_REG_W-1:0] g;
		int lane, r;
		for (lane = 0; lane < GAIN_LANES; lane++) begin
			r = $urandom_range(99);
			if (r < 15)
				g[lane*GAIN_W +: GAIN_W] = '0;
			else if (r < 25)
				g[lane*GAIN_W +: GAIN_W] = '1;
			else if (r < 40)
				g[lane*GAIN_W +: GAIN_W] = GAIN_W'($urandom);
			else
				g[lane*GAIN_W +: GAIN_W] = GAIN_W'($urandom_range(384, 1));
		end
		return g;
	endfunction

	// upper bits random: only the low 16 should land in the register
	function automatic logic [GAIN_REG_W-1:0] random_time_factor(input bit inverse);
		logic [GAIN_REG_W-1:0] d;
		int r;
		d = {$urandom, $urandom};
		r = $urandom_range(99);
		if (r < 8)
			d[TF_W-1:0] = '0;
		else if (r < 15)
			d[TF_W-1:0] = '1;
		else if (r < 30)
			d[TF_W-1:0] = TF_W'($urandom);
		else if (inverse)
			d[TF_W-1:0] = TF_W'($urandom_range(256, 128));
		else
			d[TF_W-1:0] = TF_W'($urandom_range(768, 1));
		return d;
	endfunction

	always @(negedge clk) begin
		if (hold_rx) begin
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_run == 0) begin
				stall_level = ($urandom_range(99) >= 55);
				stall_run = pick_len();
			end
			stall_run--;
			out_stall <= stall_level;
		end
	end

	always @(posedge clk) begin : check_drive
		drive_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_drives.size() == 0) begin
				$error("unexpected result: wheel_id %0d drive_value %0d was_clamped %0b",
					wheel_id, drive_value, was_clamped);
				mismatch_count++;
			end else begin
				want = pending_drives.pop_front();
				if (wheel_id !== want.wheel) begin
					$error("wheel_id: expected %0d, got %0d", want.wheel, wheel_id);
					mismatch_count++;
				end
				if (drive_value !== want.drive) begin
					$error("drive_value: expected %0d, got %0d", want.drive, drive_value);
					mismatch_count++;
				end
				if (was_clamped !== want.clamped) begin
					$error("was_clamped: expected %0b, got %0b", want.clamped, was_clamped);
					mismatch_count++;
				end
			end
		end
	end

	// called and returns at a falling edge; valid stays up across back-to-back requests
	task automatic send_request(input logic [WHEEL_W-1:0] w,
		input logic signed [SPEED_W-1:0] meas, input logic signed [SPEED_W-1:0] targ);
		int gap;
		gap = (quiet || $urandom_range(99) < 50) ? 0 : pick_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		wheel_index <= w;
		measured_speed <= meas;
		target_speed <= targ;
		do @(posedge clk); while (in_stall);
		pending_drives.push_back(predict_drive(w, meas, targ));
		@(negedge clk);
	endtask

	task automatic random_request();
		logic signed [SPEED_W-1:0] targ, meas;
		if ($urandom_range(99) < 40)
			targ = SPEED_W'($urandom);
		else
			targ = SPEED_W'(int'($urandom_range(8191)) - 4096);
		// mostly track the target closely so the drive stays out of the clamp
		if ($urandom_range(99) < 35)
			meas = SPEED_W'($urandom);
		else
			meas = SPEED_W'(int'(targ) + int'($urandom_range(1023)) - 512);
		send_request(WHEEL_W'($urandom_range(WHEEL_COUNT - 1)), meas, targ);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_drives.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [GAIN_REG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		unique case (idx)
			REG_KP: kp_gains = data;
			REG_KI: ki_gains = data;
			REG_KD: kd_gains = data;
			REG_TF: tf_q8 = data[TF_W-1:0];
			REG_ITF: itf_q8 = data[TF_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [GAIN_REG_W-1:0] kp, input logic [GAIN_REG_W-1:0] ki,
		input logic [GAIN_REG_W-1:0] kd, input logic [GAIN_REG_W-1:0] tf,
		input logic [GAIN_REG_W-1:0] itf);
		cfg_write(REG_KP, kp);
		cfg_write(REG_KI, ki);
		cfg_write(REG_KD, kd);
		cfg_write(REG_TF, tf);
		cfg_write(REG_ITF, itf);
	endtask

	// zero gains after reset: every drive is zero
	task automatic test_reset_defaults();
		send_request(2'd0, SPEED_MAX, SPEED_MIN);
		send_request(2'd1, SPEED_MIN, SPEED_MAX);
		send_request(2'd2, '0, '0);
		send_request(2'd3, SPEED_MAX, SPEED_MAX);
		drain();
	endtask

	// pure P term with both time factors zero; wheel 3 at kp 1.0 hits the clamp edge
	task automatic test_proportional_clamp();
		int idx;
		set_config({Q8_ONE, {(GAIN_REG_W-GAIN_W){1'b1}}}, '0, '0,
			64'hFFFF_FFFF_FFFF_0000, 64'hA5A5_0000_0000_0000);
		for (idx = int'(REG_ITF) + 1; idx < (1 << CFG_IDX_W); idx++)
			cfg_write(CFG_IDX_W'(idx), ALL_ONES);
		send_request(2'd0, 19'sd1, '0);
		send_request(2'd1, '0, 19'sd1);
		send_request(2'd2, SPEED_MAX, SPEED_MIN);
		send_request(2'd0, SPEED_MIN, SPEED_MAX);
		send_request(2'd3, 19'sd12800, '0);
		send_request(2'd3, '0, 19'sd12800);
		send_request(2'd3, 19'sd12801, '0);
		send_request(2'd3, -19'sd1, 19'sd12800);
		drain();
	endtask

	// wheel 0 saturates high, wheel 1 low, then each is pushed the other way
	task automatic test_integral_saturation();
		set_config('0, ALL_ONES, '0, GAIN_REG_W'(Q8_ONE), 64'hFFFF);
		send_request(2'd0, SPEED_MAX, SPEED_MIN);
		send_request(2'd1, SPEED_MIN, SPEED_MAX);
		send_request(2'd0, SPEED_MIN, SPEED_MAX);
		send_request(2'd1, SPEED_MAX, SPEED_MIN);
		send_request(2'd2, '0, '0);
		drain();
	endtask

	task automatic test_derivative();
		set_config('0, '0, 64'h0001_0002_0040_0100, 64'hFFFF, 64'h0001);
		send_request(2'd0, 19'sd100, '0);
		send_request(2'd1, -19'sd100, '0);
		send_request(2'd2, 19'sd5000, '0);
		send_request(2'd3, SPEED_MAX, SPEED_MIN);
		send_request(2'd3, SPEED_MIN, SPEED_MAX);
		send_request(2'd0, '0, '0);
		drain();
	endtask

	task automatic test_random_phases();
		int phase;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain();
			set_config(random_gains(), random_gains(), random_gains(),
				random_time_factor(1'b0), random_time_factor(1'b1));
			if ($urandom_range(99) < 20)
				cfg_write(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, int'(REG_ITF) + 1)),
					{$urandom, $urandom});
			repeat (PHASE_REQUESTS) random_request();
		end
		drain();
	endtask

	// receiver holds off while requests keep coming, so in_stall must rise
	task automatic test_receiver_hold();
		drain();
		fork
			begin
				hold_rx = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end
			repeat (40) random_request();
		join
		drain();
	endtask

	task automatic test_back_to_back();
		drain();
		quiet = 1'b1;
		repeat (30) random_request();
		drain();
		quiet = 1'b0;
	endtask

	initial begin
		model_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_proportional_clamp();
		test_integral_saturation();
		test_derivative();
		test_random_phases();
		test_receiver_hold();
		test_back_to_back();
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_drives.size() == 0) begin
			$display("tb_multi_wheel_pid_speed_controller: done, clean");
		end else begin
			$display("tb_multi_wheel_pid_speed_controller: done, errors");
		end
		$finish;
	end

	initial begin
		#(WATCHDOG_CYCLES * CLK_PERIOD);
		$display("timeout waiting for results");
		$display("tb_multi_wheel_pid_speed_controller: done, errors");
		$finish;
	end

endmodule
